// ===== design/sum_over_threshold_penalty_macros.svh =====
// Assertion macros shared by the threshold excess summer.
`ifndef SUM_OVER_THRESHOLD_PENALTY_MACROS_SVH
`define SUM_OVER_THRESHOLD_PENALTY_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SOTP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SOTP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sotp_pkg.sv =====
// Package: sizes, codes and control structs of the threshold excess summer.
`timescale 1ns / 1ps
package sotp_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int VALUE_W     = 24;
  localparam int INDEX_W     = 6;
  localparam int COUNT_REG_W = 7;
  localparam int TERM_W      = 2 * VALUE_W;
  localparam int ACC_W       = 62;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = COUNT_REG_W;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_SQUARE_MODE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT = 1'd1;

  localparam logic [COUNT_REG_W-1:0] ENTRY_COUNT_RESET = 7'd64;

  typedef enum logic {
    OP_WRITE     = 1'b0,
    OP_THRESHOLD = 1'b1
  } opcode_t;

  // Control from the sequencer to the excess datapath.
  typedef struct packed {
    logic clear;
    logic issue;
    logic square;
  } walk_ctl_t;

  // Status back from the datapath.
  typedef struct packed {
    logic busy;
  } walk_sts_t;

endpackage

// ===== design/sum_over_threshold_penalty.sv =====
// Top level: threshold excess summer over a table of Q15.8 values.
//
// Input stream (s_axis): one beat is one command. tuser is the opcode
// (write a table entry or set the threshold); tdata carries the entry
// index and the signed Q15.8 value. Output stream (m_axis): one beat per
// command, the sum over entries 0..entry_count-1 of max(0, value - thr),
// each excess squared first when square_mode is set.
// Config port: cfg_we/cfg_index/cfg_data; the user must write it only
// while idle, the block itself does not enforce this. Table reads issue
// one per active entry starting the cycle after the accept, then the
// values pass the read/excess/square/add pipeline; counts above 64 act as
// 64. Reads go through the single table read port. One command at a time
// is in work: the next is taken once the previous result leaves the drain
// state. A finished result waits in the output register; the next command
// is taken meanwhile, and its result waits in the drain state until the
// receiver takes the older beat.
// Reset: table reads as zero (per-entry valid bits cleared), threshold
// zero, square_mode 0, entry_count 64. No clearing pass is needed.
`timescale 1ns / 1ps
module sum_over_threshold_penalty
  import sotp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // config write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // command stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // entry_index[5:0], data_value[29:6], zero pad
  input  logic                   s_axis_tuser,  // opcode[0]
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // total_penalty[61:0], zero pad
);

  `include "sum_over_threshold_penalty_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // config registers
  logic                   square_mode;
  logic [COUNT_REG_W-1:0] entry_count;

  // command fields
  opcode_t                in_op;
  logic [INDEX_W-1:0]     in_index;
  logic [VALUE_W-1:0]     in_value;
  logic                   in_accept;

  logic signed [VALUE_W-1:0] threshold;
  logic [TABLE_DEPTH-1:0]    entry_valid;
  logic [CNT_W-1:0]          active_cnt;
  logic [CNT_W-1:0]          walk_cnt;
  logic                      rd_ok;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [VALUE_W-1:0]     ram_rdata;

  walk_ctl_t              acc_ctl;
  walk_sts_t              acc_sts;
  logic [ACC_W-1:0]       acc_total;
  logic                   result_load;
  logic                   issue;

  assign in_op     = opcode_t'(s_axis_tuser);
  assign in_index  = s_axis_tdata[INDEX_W-1:0];
  assign in_value  = s_axis_tdata[INDEX_W+VALUE_W-1:INDEX_W];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      square_mode <= 1'b0;
      entry_count <= ENTRY_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SQUARE_MODE: square_mode <= cfg_data[0];
        REG_ENTRY_COUNT: entry_count <= cfg_data[COUNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Table write happens on the accept edge, before any read of the walk.
  assign ram_we    = in_accept && (in_op == OP_WRITE)
                     && (32'(in_index) < 32'(TABLE_DEPTH));
  assign ram_waddr = ADDR_W'(in_index);
  assign issue     = (state == ST_WALK) && (walk_cnt != active_cnt);
  assign ram_raddr = walk_cnt[ADDR_W-1:0];

  sotp_ram #(
    .DATA_W (VALUE_W),
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .re    (issue),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      threshold   <= '0;
    end else if (in_accept) begin
      if (ram_we) begin
        entry_valid[ram_waddr] <= 1'b1;
      end
      if (in_op == OP_THRESHOLD) begin
        threshold <= $signed(in_value);
      end
    end
  end

  // valid bit travels with the registered read data
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_ok <= entry_valid[ram_raddr];
    end
  end

  // sequencer
  assign result_load = (state == ST_DRAIN) && !acc_sts.busy
                       && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_accept) state_next = ST_WALK;
      ST_WALK:  if (walk_cnt == active_cnt) state_next = ST_DRAIN;
      ST_DRAIN: if (result_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      walk_cnt   <= '0;
      active_cnt <= '0;
    end else begin
      state <= state_next;
      if (in_accept) begin
        walk_cnt   <= '0;
        // counts past the table depth saturate
        active_cnt <= (32'(entry_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                            : CNT_W'(entry_count);
      end else if (issue) begin
        walk_cnt <= walk_cnt + 1'b1;
      end
    end
  end

  assign acc_ctl.clear  = in_accept;
  assign acc_ctl.issue  = issue;
  assign acc_ctl.square = square_mode;

  sotp_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .ctl       (acc_ctl),
    .rd_data   (ram_rdata),
    .rd_ok     (rd_ok),
    .threshold (threshold),
    .sts       (acc_sts),
    .total     (acc_total)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (result_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      m_axis_tdata <= OUT_TDATA_W'(acc_total);
    end
  end

  `SOTP_ASSERT_NXT(a_accept_blocks, clk, rst, in_accept, !s_axis_tready,
                   "command taken while another is in work")
  `SOTP_ASSERT_IMP(a_walk_bound, clk, rst, 1'b1, walk_cnt <= active_cnt,
                   "walk counter ran past the active entry count")
  `SOTP_ASSERT_IMP(a_result_after_drain, clk, rst, $rose(m_axis_tvalid),
                   $past(state == ST_DRAIN) && !$past(acc_sts.busy),
                   "result presented before the pipeline drained")

endmodule

// ===== design/sotp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module sotp_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/sotp_accum.sv =====
// Excess datapath: subtract threshold, clamp, optional square, accumulate.
`timescale 1ns / 1ps
module sotp_accum
  import sotp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  walk_ctl_t                 ctl,
  input  logic [VALUE_W-1:0]        rd_data,   // table word, registered, valid the cycle after issue
  input  logic                      rd_ok,     // entry written since reset
  input  logic signed [VALUE_W-1:0] threshold,
  output walk_sts_t                 sts,
  output logic [ACC_W-1:0]          total
);

  logic                      s1_valid;
  logic                      s2_valid;
  logic                      s3_valid;
  logic [VALUE_W-1:0]        excess;
  logic [TERM_W-1:0]         term;

  logic signed [VALUE_W-1:0] value_eff;
  logic signed [VALUE_W:0]   diff;

  // Unwritten entries read as zero.
  assign value_eff = rd_ok ? $signed(rd_data) : '0;
  assign diff      = {value_eff[VALUE_W-1], value_eff} - {threshold[VALUE_W-1], threshold};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= ctl.issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      excess <= (diff > 0) ? diff[VALUE_W-1:0] : '0;
    end
    if (s2_valid) begin
      term <= ctl.square ? (TERM_W'(excess) * TERM_W'(excess)) : TERM_W'(excess);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (ctl.clear) begin
      total <= '0;
    end else if (s3_valid) begin
      total <= total + ACC_W'(term);
    end
  end

  assign sts.busy = ctl.issue | s1_valid | s2_valid | s3_valid;

endmodule

// ===== test/sum_over_threshold_penalty_tb.sv =====
// Testbench: stream-driven check of the threshold excess summer against a local predictor.
`timescale 1ns / 1ps
module sum_over_threshold_penalty_tb;
  import sotp_pkg::*;

  // Q15.8 corner values
  localparam logic [VALUE_W-1:0] VAL_MIN = 24'h800000;
  localparam logic [VALUE_W-1:0] VAL_MAX = 24'h7FFFFF;
  localparam logic [VALUE_W-1:0] VAL_NEG1 = 24'hFFFFFF;

  // Settle a bit longer than one full walk.
  localparam int SETTLE_CYCLES = 80;
  // Long receiver hold-off used to back the block up into its input.
  localparam int HOLD_CYCLES = 300;
  // Quiet cycles tolerated: one full walk plus worst gaps and the hold-off, several times.
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    opcode_t               op;
    logic [INDEX_W-1:0]    idx;
    logic [VALUE_W-1:0]    value;
  } command_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // entry_index[5:0], data_value[29:6], zero pad
  logic                   s_axis_tuser = 1'b0; // opcode[0]

  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;       // total_penalty[61:0], zero pad

  always #10 clk = ~clk;

  sum_over_threshold_penalty uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: shadow copy of the table, threshold and both registers.
  // ---------------------------------------------------------------------------
  logic [VALUE_W-1:0]     shadow_table [TABLE_DEPTH];
  logic [VALUE_W-1:0]     shadow_thresh;
  logic                   square_on;
  logic [COUNT_REG_W-1:0] active_count;

  command_t    pending_cmds[$];  // commands waiting to go out as input beats
  logic [61:0] penalty_q[$];     // expected total_penalty, oldest first

  int unsigned err_count = 0;

  // Idle controls shared between the test tasks and the two stream processes.
  logic src_idle_on = 1'b0;
  logic sink_idle_on = 1'b0;
  logic hold_start = 1'b0;

  // Sum of max(0, value - threshold) over the active entries, squared per
  // entry in square mode. Counts past the table depth saturate.
  function automatic logic [61:0] excess_sum();
    int          active;
    int          i;
    logic [63:0] total;
    logic [24:0] diff;
    logic [47:0] term;
    active = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count);
    total = '0;
    for (i = 0; i < active; i++) begin
      // 25-bit signed difference cannot overflow for two 24-bit operands
      diff = {shadow_table[i][VALUE_W-1], shadow_table[i]} -
             {shadow_thresh[VALUE_W-1], shadow_thresh};
      if (!diff[24] && diff != '0) begin
        term = {24'd0, diff[23:0]};
        if (square_on) begin
          term = term * term;
        end
        total += {16'd0, term};
      end
    end
    return total[61:0];
  endfunction

  // Update the shadow state for one accepted command and queue its result.
  task automatic apply_command(input command_t cmd);
    if (cmd.op == OP_THRESHOLD) begin
      shadow_thresh = cmd.value;
    end else begin
      shadow_table[cmd.idx] = cmd.value;
    end
    penalty_q = {penalty_q, excess_sum()};
  endtask

  // ---------------------------------------------------------------------------
  // Input side: presents queued commands, holds a beat until accepted and,
  // while src_idle_on is set, sometimes inserts a random gap after an accepted beat.
  // ---------------------------------------------------------------------------
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_command(pending_cmds.pop_front());
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 6);
        end
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // beat still offered; hold it steady
      end else if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left--;
      end else if (pending_cmds.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_cmds[0].op;
        s_axis_tdata  <= {2'b00, pending_cmds[0].value, pending_cmds[0].idx};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: checks every result beat against the oldest expectation and
  // drives tready with random stall bursts (while sink_idle_on is set) or a long hold-off on request.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    logic [61:0] want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (penalty_q.size() == 0) begin
        $error("result beat with no expectation pending: total_penalty %0d",
               m_axis_tdata[61:0]);
        err_count++;
      end else begin
        want = penalty_q.pop_front();
        if (m_axis_tdata[61:0] !== want) begin
          $error("total_penalty mismatch: expected %0d, actual %0d",
                 want, m_axis_tdata[61:0]);
          err_count++;
        end
      end
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_start) begin
        hold_left = HOLD_CYCLES;
        hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        // start a stall burst of random length
        stall_left = $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: quiet cycles with no beat on either stream.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sum_over_threshold_penalty verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared helpers
  // ---------------------------------------------------------------------------

  // Queue one command; keeps a few in flight so the input can run back to back.
  task automatic send_cmd(input opcode_t op, input logic [INDEX_W-1:0] idx,
                          input logic [VALUE_W-1:0] value);
    command_t cmd;
    cmd.op = op;
    cmd.idx = idx;
    cmd.value = value;
    do @(negedge clk); while (pending_cmds.size() >= 4);
    pending_cmds = {pending_cmds, cmd};
  endtask

  // Block is idle once all commands went out and every result came back.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || penalty_q.size() != 0 || s_axis_tvalid);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_SQUARE_MODE: square_on = val[0];
      REG_ENTRY_COUNT: active_count = val;
      default: ;
    endcase
  endtask

  // Values biased toward the threshold and the format corners so that
  // excesses are both common and large.
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = VALUE_W'($urandom);
      1: v = shadow_thresh + VALUE_W'($urandom_range(0, 512)) - 24'd256;
      2: begin
        case ($urandom_range(0, 4))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = '0;
          3: v = VAL_NEG1;
          default: v = 24'd1;
        endcase
      end
      default: v = VALUE_W'($urandom_range(0, 4095)) - 24'd2048;
    endcase
    return v;
  endfunction

  function automatic logic [COUNT_REG_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return COUNT_REG_W'($urandom_range(TABLE_DEPTH + 1, 127));
      2: return COUNT_REG_W'(TABLE_DEPTH);
      3: return 7'd1;
      default: return COUNT_REG_W'($urandom_range(1, TABLE_DEPTH));
    endcase
  endfunction

  task automatic send_random(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      send_cmd(($urandom_range(0, 4) == 0) ? OP_THRESHOLD : OP_WRITE,
               INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)), pick_value());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Table and threshold come out of reset as zero: nothing exceeds.
  task automatic test_reset_state();
    send_cmd(OP_THRESHOLD, '0, '0);
    send_cmd(OP_WRITE, 6'd63, '0);
  endtask

  // Plain sums at the value extremes, equal-to-threshold entries and both
  // ends of the index range.
  task automatic test_linear_extremes();
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    send_cmd(OP_WRITE, 6'd0, VAL_MAX);
    send_cmd(OP_WRITE, 6'd63, 24'd1);        // smallest nonzero excess
    send_cmd(OP_WRITE, 6'd32, VAL_MIN);
    send_cmd(OP_THRESHOLD, '0, VAL_MIN);     // widest excess; entry 32 sits exactly on it
    send_cmd(OP_THRESHOLD, '0, VAL_MAX);     // entry 0 equals threshold, all others below
    send_cmd(OP_THRESHOLD, '0, VAL_NEG1);
    send_cmd(OP_WRITE, 6'd42, 24'hAAAAAA);
    send_cmd(OP_WRITE, 6'd21, 24'h555555);
    send_cmd(OP_THRESHOLD, '0, '0);
  endtask

  // Squared excesses, including the largest possible term on entries 0 and 5.
  task automatic test_square_extremes();
    write_reg(REG_SQUARE_MODE, 7'd1);
    send_cmd(OP_THRESHOLD, '0, VAL_MIN);
    send_cmd(OP_WRITE, 6'd5, VAL_MAX);
    send_cmd(OP_THRESHOLD, '0, 24'h7FFFFE);  // entries 0 and 5 each exceed by 1, squared
    send_cmd(OP_THRESHOLD, '0, '0);
  endtask

  // Active entry count: none, one, beyond the table (saturates), then back to full.
  task automatic test_entry_count();
    write_reg(REG_ENTRY_COUNT, 7'd0);
    send_cmd(OP_THRESHOLD, '0, VAL_MIN);
    write_reg(REG_ENTRY_COUNT, 7'd1);
    send_cmd(OP_WRITE, 6'd1, VAL_MAX);
    write_reg(REG_ENTRY_COUNT, 7'd127);
    send_cmd(OP_WRITE, 6'd63, VAL_MAX);
    write_reg(REG_SQUARE_MODE, 7'd0);
    write_reg(REG_ENTRY_COUNT, 7'd65);
    send_cmd(OP_THRESHOLD, '0, 24'd256);
    write_reg(REG_ENTRY_COUNT, ENTRY_COUNT_RESET);
  endtask

  // Receiver holds off long enough for one result to sit in the output
  // register, the next in the drain state, and the input to stall.
  task automatic test_stall_pressure();
    wait_idle();
    src_idle_on = 1'b0;
    @(negedge clk);
    hold_start = 1'b1;
    send_random(8);
  endtask

  // Random phases, each under a fresh register setting; idling varies per
  // phase so some stretches run without any gaps.
  task automatic test_random_phases();
    int phase;
    for (phase = 0; phase < 12; phase++) begin
      write_reg(REG_SQUARE_MODE, COUNT_REG_W'($urandom_range(0, 1)));
      write_reg(REG_ENTRY_COUNT, pick_count());
      src_idle_on = (phase % 4) < 2;
      sink_idle_on = (phase % 4) == 0 || (phase % 4) == 2;
      send_random(100);
    end
  endtask

  // Last stretch: full configuration, no idling anywhere.
  task automatic test_full_rate();
    write_reg(REG_SQUARE_MODE, 7'd1);
    write_reg(REG_ENTRY_COUNT, COUNT_REG_W'(TABLE_DEPTH));
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    send_random(100);
  endtask

  initial begin
    int i;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      shadow_table[i] = '0;
    end
    shadow_thresh = '0;
    square_on = 1'b0;
    active_count = ENTRY_COUNT_RESET;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_linear_extremes();
    test_square_extremes();
    test_entry_count();
    test_stall_pressure();
    test_random_phases();
    test_full_rate();

    wait_idle();
    if (err_count == 0) begin
      $display("sum_over_threshold_penalty verification clean");
    end else begin
      $display("sum_over_threshold_penalty verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/sotp_pkg.sv
design/sotp_ram.sv
design/sotp_accum.sv
design/sum_over_threshold_penalty.sv
test/sum_over_threshold_penalty_tb.sv
